>>> design/assert_macros.svh
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset cycles included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/thtr_pkg.sv
`default_nettype none
package thtr_pkg;

    // Stream word widths
    localparam int IN_TDATA_W  = 56;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 88;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_CAP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNITS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RECL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RISE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd6;

    // Command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_WEATHER = 2'd1;
    localparam logic [1:0] CMD_PROT    = 2'd2;
    localparam logic [1:0] CMD_TICK    = 2'd3;

    // Register reset values
    localparam logic [15:0] CAP_RST   = 16'd640;
    localparam logic [15:0] FIRM_RST  = 16'd0;
    localparam logic [3:0]  UNITS_RST = 4'd1;
    localparam logic [14:0] TRIP_RST  = 15'd7040;
    localparam logic [14:0] RECL_RST  = 15'd5760;
    localparam logic [14:0] RISE_RST  = 15'd3520;
    localparam logic [15:0] GAIN_RST  = 16'd273;

    // State reset values
    localparam logic [31:0] OIL_RST = 32'd188743680;   // 45 C in 1/64 C, 16 fraction bits
    localparam logic [15:0] AMB_RST = 16'd1600;
    localparam logic [15:0] PF_RST  = 16'd31130;

    localparam logic [15:0] MIN_CAP = 16'd16;
    localparam logic signed [48:0] TGT_MAX = 49'sh0400000000000;

    // Shared compare-subtract unit and multiplier
    localparam int CSU_W  = 34;
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // Step counts minus one for the serial passes
    localparam logic [5:0] SQ_LAST = 6'd15;
    localparam logic [5:0] PF_LAST = 6'd30;
    localparam logic [5:0] RD_LAST = 6'd62;

    typedef struct packed {
        logic             ge;
        logic [CSU_W-1:0] diff;
    } t_csu_res;

endpackage
`default_nettype wire

>>> design/transformer_thermal_trip_model_top.sv
`default_nettype none
// Transformer thermal trip relay. Each input word applies its command (load
// report, weather, protection or tick only) and then runs one thermal tick,
// producing one result word. The power factor is left alone when P^2+Q^2 is
// below 3. The slave side is not ready from acceptance until the result is
// written to the output register. A single compare-subtract unit resolves one
// bit per cycle for the square root, the power factor divide and the rise
// divide. One shared registered multiplier forms the squares, the rise product
// and the lag product, the latter in two halves. A finished result waits in
// the output register while the next word is accepted; a second result is
// not written there until the first is taken. Configuration writes take
// effect at once and belong in idle time.
// s_axis tdata, lowest bit up: has_active, active_power, has_reactive,
// reactive_power, has_temp, temp_value, has_trip, trip_value; tuser: cmd.
// m_axis tdata, lowest bit up: oil_temp, tripped, apparent_power,
// power_factor_out, n1_secure, load_active, load_reactive.
module transformer_thermal_trip_model_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [thtr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [thtr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Slave side
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // has_active, active_power, has_reactive, reactive_power, has_temp,
    // temp_value, has_trip, trip_value
    input  wire logic [thtr_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // cmd
    input  wire logic [thtr_pkg::IN_TUSER_W-1:0]   i_s_axis_tuser,
    // Master side
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // oil_temp, tripped, apparent_power, power_factor_out, n1_secure,
    // load_active, load_reactive
    output logic [thtr_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);
    import thtr_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MP   = 5'd1;
    localparam logic [4:0] S_MQ   = 5'd2;
    localparam logic [4:0] S_MC   = 5'd3;
    localparam logic [4:0] S_MR   = 5'd4;
    localparam logic [4:0] S_SI   = 5'd5;
    localparam logic [4:0] S_SQ   = 5'd6;
    localparam logic [4:0] S_PI   = 5'd7;
    localparam logic [4:0] S_PF   = 5'd8;
    localparam logic [4:0] S_PS   = 5'd9;
    localparam logic [4:0] S_RI   = 5'd10;
    localparam logic [4:0] S_RD   = 5'd11;
    localparam logic [4:0] S_TG   = 5'd12;
    localparam logic [4:0] S_ML   = 5'd13;
    localparam logic [4:0] S_MH   = 5'd14;
    localparam logic [4:0] S_UP   = 5'd15;
    localparam logic [4:0] S_TR   = 5'd16;
    localparam logic [4:0] S_N1   = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    localparam logic signed [50:0] OIL_MAX = 51'sd2147483647;
    localparam logic signed [50:0] OIL_MIN = -51'sd2147483648;

    // Input word fields
    logic        in_acc;
    logic [1:0]  in_cmd;
    logic        in_has_act, in_has_rea, in_has_temp, in_has_trip, in_trip_val;
    logic [15:0] in_act, in_rea, in_temp;

    // Configuration registers
    logic [15:0] r_cap, r_firm, r_gain;
    logic [3:0]  r_units;
    logic [14:0] r_trip_t, r_recl_t, r_rise;

    // Model state
    logic signed [15:0] r_act, r_rea, r_amb, r_pf;
    logic signed [31:0] r_oil;
    logic               r_trip;

    // Sequencer and work registers
    logic [4:0]         r_state, n_state;
    logic [5:0]         r_cnt;
    logic [31:0]        r_s2, r_capsq;
    logic [CSU_W-1:0]   r_rem;
    logic [62:0]        r_q, r_dvd;
    logic [15:0]        r_s;
    logic signed [48:0] r_diff;
    logic [47:0]        r_plo;
    logic               r_hot, r_n1;
    logic               r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;

    // Shared units
    logic                     mul_en;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] prod;
    logic [CSU_W-1:0]         csu_a, csu_b;
    t_csu_res                 csu_res;
    logic                     step_sqrt;
    logic [31:0]              divisor;

    // Tick arithmetic
    logic [15:0]        cap_eff, absp, pf_pos;
    logic signed [15:0] pf_val;
    logic [48:0]        amb49, sum49;
    logic signed [48:0] target;
    logic               rise_sat;
    logic [65:0]        full66;
    logic [49:0]        shr50;
    logic [50:0]        nxt51;
    logic signed [31:0] oil_next;
    logic               trip_hi, recl_lo;
    logic [31:0]        s2_after;
    logic               out_free;

    assign in_acc      = i_s_axis_tvalid & o_s_axis_tready;
    assign in_cmd      = i_s_axis_tuser[1:0];
    assign in_has_act  = i_s_axis_tdata[0];
    assign in_act      = i_s_axis_tdata[16:1];
    assign in_has_rea  = i_s_axis_tdata[17];
    assign in_rea      = i_s_axis_tdata[33:18];
    assign in_has_temp = i_s_axis_tdata[34];
    assign in_temp     = i_s_axis_tdata[50:35];
    assign in_has_trip = i_s_axis_tdata[51];
    assign in_trip_val = i_s_axis_tdata[52];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign out_free        = ~r_ovalid | i_m_axis_tready;

    assign cap_eff = (r_cap < MIN_CAP) ? MIN_CAP : r_cap;
    assign absp    = r_act[15] ? (~r_act + 16'd1) : r_act;

    // Feed the multiplier by sequencer step
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            S_MP: begin
                mul_en = 1'b1;
                mul_a  = {{17{r_act[15]}}, r_act};
                mul_b  = {r_act[15], r_act};
            end
            S_MQ: begin
                mul_en = 1'b1;
                mul_a  = {{17{r_rea[15]}}, r_rea};
                mul_b  = {r_rea[15], r_rea};
            end
            S_MC: begin
                mul_en = 1'b1;
                mul_a  = {17'd0, cap_eff};
                mul_b  = {1'b0, cap_eff};
            end
            S_MR: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_s2};
                mul_b  = {2'd0, r_rise};
            end
            S_ML: begin
                mul_en = 1'b1;
                mul_a  = {1'b0, r_diff[31:0]};
                mul_b  = {1'b0, r_gain};
            end
            S_MH: begin
                mul_en = 1'b1;
                mul_a  = {{16{r_diff[48]}}, r_diff[48:32]};
                mul_b  = {1'b0, r_gain};
            end
            S_TR: begin
                mul_en = 1'b1;
                mul_a  = {17'd0, r_firm};
                mul_b  = {1'b0, r_firm};
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    thtr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // Shift in the next bits and set the trial value
    assign step_sqrt = (r_state == S_SQ);
    assign divisor   = (r_state == S_PF) ? {16'd0, r_s} : r_capsq;
    assign csu_a     = step_sqrt ? {r_rem[31:0], r_dvd[62:61]} : {r_rem[32:0], r_dvd[62]};
    assign csu_b     = step_sqrt ? {r_q[31:0], 2'b01} : {2'd0, divisor};

    thtr_csu u_csu (
        .i_a   (csu_a),
        .i_b   (csu_b),
        .o_res (csu_res)
    );

    // Power factor with sign and positive saturation
    assign pf_pos = (r_q[30:0] > 31'd32767) ? 16'h7FFF : r_q[15:0];
    assign pf_val = r_act[15] ? (~r_q[15:0] + 16'd1) : pf_pos;

    // Target oil value, saturated
    assign amb49    = {{17{r_amb[15]}}, r_amb, 16'd0};
    assign sum49    = amb49 + {3'd0, r_q[45:0]};
    assign rise_sat = |r_q[62:46];
    assign target   = (rise_sat || ($signed(sum49) > TGT_MAX)) ? TGT_MAX : $signed(sum49);

    // Lag step: join the two partial products, floor shift, clamp
    assign full66   = {prod[33:0], 32'd0} + {18'd0, r_plo};
    assign shr50    = full66[65:16];
    assign nxt51    = {shr50[49], shr50} + {{19{r_oil[31]}}, r_oil};
    assign oil_next = ($signed(nxt51) > OIL_MAX) ? 32'sh7FFFFFFF :
                      ($signed(nxt51) < OIL_MIN) ? 32'sh80000000 : nxt51[31:0];

    assign trip_hi  = r_oil > $signed({1'b0, r_trip_t, 16'd0});
    assign recl_lo  = r_oil < $signed({1'b0, r_recl_t, 16'd0});
    assign s2_after = r_hot ? 32'd0 : r_s2;

    // Sequence the tick
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_MP;
            S_MP:   n_state = S_MQ;
            S_MQ:   n_state = S_MC;
            S_MC:   n_state = S_MR;
            S_MR:   n_state = S_SI;
            S_SI:   n_state = S_SQ;
            S_SQ:   if (r_cnt == '0) n_state = S_PI;
            S_PI:   n_state = (r_s2 >= 32'd3) ? S_PF : S_RI;
            S_PF:   if (r_cnt == '0) n_state = S_PS;
            S_PS:   n_state = S_RI;
            S_RI:   n_state = S_RD;
            S_RD:   if (r_cnt == '0) n_state = S_TG;
            S_TG:   n_state = S_ML;
            S_ML:   n_state = S_MH;
            S_MH:   n_state = S_UP;
            S_UP:   n_state = S_TR;
            S_TR:   n_state = S_N1;
            S_N1:   n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control, configuration and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_cap    <= CAP_RST;
            r_firm   <= FIRM_RST;
            r_units  <= UNITS_RST;
            r_trip_t <= TRIP_RST;
            r_recl_t <= RECL_RST;
            r_rise   <= RISE_RST;
            r_gain   <= GAIN_RST;
            r_act    <= '0;
            r_rea    <= '0;
            r_oil    <= OIL_RST;
            r_amb    <= AMB_RST;
            r_trip   <= 1'b0;
            r_pf     <= PF_RST;
        end else begin
            r_state <= n_state;

            // Write a configuration register
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CAP:   r_cap    <= i_cfg_data;
                    REG_FIRM:  r_firm   <= i_cfg_data;
                    REG_UNITS: r_units  <= i_cfg_data[3:0];
                    REG_TRIP:  r_trip_t <= i_cfg_data[14:0];
                    REG_RECL:  r_recl_t <= i_cfg_data[14:0];
                    REG_RISE:  r_rise   <= i_cfg_data[14:0];
                    REG_GAIN:  r_gain   <= i_cfg_data;
                    default:   r_cap    <= r_cap;
                endcase
            end

            // Drop the result word once taken
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (in_cmd)
                            CMD_LOAD: begin
                                if (in_has_act)  r_act <= in_act;
                                if (in_has_rea)  r_rea <= in_rea;
                                if (in_has_temp) r_oil <= {in_temp, 16'd0};
                            end
                            CMD_WEATHER: begin
                                if (in_has_temp) r_amb <= in_temp;
                            end
                            CMD_PROT: begin
                                if (in_has_trip) r_trip <= in_trip_val;
                            end
                            CMD_TICK: begin
                                r_trip <= r_trip;
                            end
                            default: begin
                                r_trip <= r_trip;
                            end
                        endcase
                    end
                end
                S_SI: r_cnt <= SQ_LAST;
                S_PI: r_cnt <= PF_LAST;
                S_RI: r_cnt <= RD_LAST;
                S_SQ, S_PF, S_RD: r_cnt <= r_cnt - 6'd1;
                S_PS: r_pf <= pf_val;
                S_UP: r_oil <= oil_next;
                S_TR: begin
                    if (trip_hi) begin
                        r_trip <= 1'b1;
                        r_act  <= '0;
                        r_rea  <= '0;
                    end else if (r_trip && recl_lo) begin
                        r_trip <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (out_free) r_ovalid <= 1'b1;
                end
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // Work registers of the datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_MQ: r_s2 <= prod[31:0];
            S_MC: r_s2 <= r_s2 + prod[31:0];
            S_MR: r_capsq <= prod[31:0];
            S_SI: begin
                r_dvd <= {r_s2, 31'd0};
                r_rem <= '0;
                r_q   <= '0;
            end
            S_PI: begin
                r_s   <= r_q[15:0];
                r_dvd <= {absp, 15'd0, 32'd0};
                r_rem <= '0;
                r_q   <= '0;
            end
            S_RI: begin
                r_dvd <= {prod[46:0], 16'd0};
                r_rem <= '0;
                r_q   <= '0;
            end
            S_SQ: begin
                r_dvd <= {r_dvd[60:0], 2'd0};
                r_rem <= csu_res.ge ? csu_res.diff : csu_a;
                r_q   <= {r_q[61:0], csu_res.ge};
            end
            S_PF, S_RD: begin
                r_dvd <= {r_dvd[61:0], 1'b0};
                r_rem <= csu_res.ge ? csu_res.diff : csu_a;
                r_q   <= {r_q[61:0], csu_res.ge};
            end
            S_TG: r_diff <= target - $signed({{17{r_oil[31]}}, r_oil});
            S_MH: r_plo  <= prod[47:0];
            S_TR: r_hot  <= trip_hi;
            S_N1: r_n1   <= (r_units > 4'd1) && (s2_after <= prod[31:0]);
            S_OUT: begin
                if (out_free) begin
                    r_odata <= {6'd0, r_rea, r_act, r_n1, r_pf, r_s, r_trip, r_oil[31:16]};
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/thtr_csu.sv
`default_nettype none
module thtr_csu (
    input  wire logic [thtr_pkg::CSU_W-1:0] i_a,
    input  wire logic [thtr_pkg::CSU_W-1:0] i_b,
    output thtr_pkg::t_csu_res               o_res
);
    import thtr_pkg::*;

    logic [CSU_W:0] sub;

    // Compare and subtract in one carry chain
    assign sub        = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~sub[CSU_W];
    assign o_res.diff = sub[CSU_W-1:0];

endmodule
`default_nettype wire

>>> design/thtr_mul.sv
`default_nettype none
module thtr_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [thtr_pkg::MUL_AW-1:0] i_a,
    input  wire logic signed [thtr_pkg::MUL_BW-1:0] i_b,
    output logic signed [thtr_pkg::MUL_PW-1:0]      o_p
);
    import thtr_pkg::*;

    logic signed [MUL_PW-1:0] r_p;

    // Register the product; hold it while idle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

>>> design/thtr_chk.sv
`default_nettype none
`include "assert_macros.svh"
module thtr_chk (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              i_s_tready,
    input wire logic                              i_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [thtr_pkg::OUT_TDATA_W-1:0]  i_m_tdata
);
    import thtr_pkg::*;

    // Hold a stalled result word
    `CHK_ASSERT(a_m_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> i_m_tvalid, "result word dropped while stalled")
    `CHK_ASSERT(a_m_stable, i_clk, i_rst_n, i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata), "result word changed while stalled")

    // One word at a time: busy right after an accept
    `CHK_ASSERT(a_s_busy, i_clk, i_rst_n, i_s_tvalid && i_s_tready |=> !i_s_tready, "input accepted while busy")

    // Come out of reset idle with no result pending
    `CHK_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !i_m_tvalid, "result pending after reset")
    `CHK_ASSERT_ALWAYS(a_rst_rdy, i_clk, !i_rst_n |=> i_s_tready, "not ready after reset")

endmodule

bind transformer_thermal_trip_model_top thtr_chk u_thtr_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_axis_tvalid),
    .i_s_tready (o_s_axis_tready),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);
`default_nettype wire

>>> tb/sv/transformer_thermal_trip_model_top_tb.sv
`default_nettype none
module transformer_thermal_trip_model_top_tb;
    import thtr_pkg::*;

    // Write to this index is dropped by the block
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [1:0]         cmd;
        logic               has_p;
        logic signed [15:0] p;
        logic               has_q;
        logic signed [15:0] q;
        logic               has_t;
        logic signed [15:0] t;
        logic               has_trip;
        logic               trip_v;
    } relay_word_t;

    typedef struct {
        logic signed [15:0] oil;
        logic               tripped;
        logic [15:0]        apparent;
        logic signed [15:0] pf;
        logic               n1;
        logic signed [15:0] ld_p;
        logic signed [15:0] ld_q;
    } relay_status_t;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          val;
        relay_word_t          w;
        bit                   typed;
        relay_status_t        spec;
    } stim_row_t;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx       = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data      = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]   i_s_axis_tuser  = '0;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;

    // Relay state and register file of the predictor
    longint ld_p_st, ld_q_st, oil_acc, amb_st, pf_st;
    bit     trip_st;
    longint relay_reg [7];

    relay_status_t predicted_status [$];
    int n_fail     = 0;
    int n_sent     = 0;
    int n_checked  = 0;
    int n_trip_seen = 0;
    int n_secure_seen = 0;
    int n_settings = 0;

    // Sink-side bookkeeping
    int sink_taken = 0;
    int sink_hold  = 0;
    bit hold_done  = 1'b0;

    transformer_thermal_trip_model_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint int_sqrt(longint v);
        longint r;
        longint t;
        int     b;
        r = 0;
        for (b = 16; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Apply one command, run one thermal tick, return the status word
    function automatic relay_status_t thermal_tick_predict(relay_word_t w);
        relay_status_t r;
        longint s2, s, mag, pf, cap, rise, target, next, tgt_max;
        tgt_max = TGT_MAX;
        case (w.cmd)
            CMD_LOAD: begin
                if (w.has_p) ld_p_st = w.p;
                if (w.has_q) ld_q_st = w.q;
                if (w.has_t) oil_acc = longint'(w.t) * 65536;
            end
            CMD_WEATHER: if (w.has_t) amb_st = w.t;
            CMD_PROT:    if (w.has_trip) trip_st = w.trip_v;
            default: ;
        endcase

        s2 = ld_p_st * ld_p_st + ld_q_st * ld_q_st;
        s  = int_sqrt(s2);

        // Refresh power factor only above 0.1 MVA
        if (s2 * 100 > 256) begin
            mag = (ld_p_st < 0 ? -ld_p_st : ld_p_st) << 15;
            pf  = mag / s;
            if (ld_p_st < 0) pf = -pf;
            if (pf > 32767) pf = 32767;
            if (pf < -32768) pf = -32768;
            pf_st = pf;
        end

        // Move oil toward ambient plus load-scaled rise
        cap = relay_reg[REG_CAP];
        if (cap < MIN_CAP) cap = MIN_CAP;
        rise   = (relay_reg[REG_RISE] * s2 * 65536) / (cap * cap);
        target = amb_st * 65536;
        if (rise >= tgt_max) target = tgt_max;
        else target += rise;
        if (target > tgt_max) target = tgt_max;
        next = oil_acc + (((target - oil_acc) * relay_reg[REG_GAIN]) >>> 16);
        if (next > 64'sd2147483647) next = 64'sd2147483647;
        if (next < -64'sd2147483648) next = -64'sd2147483648;
        oil_acc = next;

        // Trip drops the load, reclose below the lower point
        if (oil_acc > relay_reg[REG_TRIP] * 65536) begin
            trip_st = 1'b1;
            ld_p_st = 0;
            ld_q_st = 0;
        end else if (trip_st && oil_acc < relay_reg[REG_RECL] * 65536) begin
            trip_st = 1'b0;
        end

        r.oil      = 16'(oil_acc >>> 16);
        r.tripped  = trip_st;
        r.apparent = (s > 65535) ? 16'hFFFF : 16'(s);
        r.pf       = 16'(pf_st);
        r.n1       = (relay_reg[REG_UNITS] > 1) &&
                     (ld_p_st * ld_p_st + ld_q_st * ld_q_st <=
                      relay_reg[REG_FIRM] * relay_reg[REG_FIRM]);
        r.ld_p     = 16'(ld_p_st);
        r.ld_q     = 16'(ld_q_st);
        return r;
    endfunction

    function automatic stim_row_t dir_item(logic [1:0] c, int hp, int p, int hq, int q,
                                           int ht, int t, int htr, int tv);
        stim_row_t row;
        row.is_cfg     = 1'b0;
        row.idx        = '0;
        row.val        = '0;
        row.typed      = 1'b0;
        row.w.cmd      = c;
        row.w.has_p    = hp[0];
        row.w.p        = 16'(p);
        row.w.has_q    = hq[0];
        row.w.q        = 16'(q);
        row.w.has_t    = ht[0];
        row.w.t        = 16'(t);
        row.w.has_trip = htr[0];
        row.w.trip_v   = tv[0];
        return row;
    endfunction

    function automatic stim_row_t dir_cfg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        stim_row_t row;
        row = dir_item(CMD_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        return row;
    endfunction

    function automatic logic signed [15:0] pick_power();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) return 16'(int'($urandom_range(0, 2400)) - 1200);
        if (sel < 80) return 16'($urandom);
        if (sel < 90) return 16'(int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 2))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            default: return 16'sh0000;
        endcase
    endfunction

    // Load reports most often, near the thermal limits, with noise in unused fields
    function automatic relay_word_t random_word();
        relay_word_t w;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) w.cmd = CMD_LOAD;
        else if (sel < 65) w.cmd = CMD_WEATHER;
        else if (sel < 82) w.cmd = CMD_PROT;
        else w.cmd = CMD_TICK;
        w.has_p    = ($urandom_range(0, 99) < 70);
        w.p        = pick_power();
        w.has_q    = ($urandom_range(0, 99) < 70);
        w.q        = pick_power();
        w.has_trip = ($urandom_range(0, 99) < 60);
        w.trip_v   = ($urandom_range(0, 99) < 40);
        if (w.cmd == CMD_LOAD) begin
            w.has_t = ($urandom_range(0, 99) < 30);
            w.t     = ($urandom_range(0, 99) < 75) ? 16'($urandom_range(3500, 9000))
                                                   : 16'($urandom);
        end else begin
            w.has_t = ($urandom_range(0, 99) < 70);
            w.t     = ($urandom_range(0, 99) < 75)
                      ? 16'(int'($urandom_range(0, 5000)) - 1000) : 16'($urandom);
        end
        return w;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_UNITS:                    relay_reg[idx] = val & 16'h000F;
            REG_TRIP, REG_RECL, REG_RISE: relay_reg[idx] = val & 16'h7FFF;
            REG_SPARE: ;
            default:                      relay_reg[idx] = val;
        endcase
    endtask

    // Stop offering and wait until every predicted word has come back
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (predicted_status.size() != 0) @(posedge i_clk);
    endtask

    // Offer one word, hold until accepted, then record its prediction
    task automatic offer(relay_word_t w, bit typed, relay_status_t spec);
        relay_status_t pred;
        bit calm;
        calm = (n_sent >= 400 && n_sent < 520);
        if (!calm && $urandom_range(0, 99) < 24) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, w.trip_v, w.has_trip, w.t, w.has_t,
                            w.q, w.has_q, w.p, w.has_p};
        i_s_axis_tuser  <= w.cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pred = thermal_tick_predict(w);
        predicted_status.push_back(typed ? spec : pred);
        n_sent++;
    endtask

    task automatic check_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // Sink: random backpressure, one long hold-off, one stretch always ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) sink_taken <= sink_taken + 1;
            if (sink_hold != 0) begin
                i_m_axis_tready <= 1'b0;
                sink_hold <= sink_hold - 1;
            end else if (!hold_done && sink_taken == 250) begin
                i_m_axis_tready <= 1'b0;
                sink_hold <= 500;
                hold_done <= 1'b1;
            end else if (sink_taken >= 380 && sink_taken < 520) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= ($urandom_range(0, 99) >= 24);
            end
        end
    end

    // Compare each accepted status word with the oldest prediction
    always @(posedge i_clk) begin
        relay_status_t got;
        relay_status_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.oil      = o_m_axis_tdata[15:0];
            got.tripped  = o_m_axis_tdata[16];
            got.apparent = o_m_axis_tdata[32:17];
            got.pf       = o_m_axis_tdata[48:33];
            got.n1       = o_m_axis_tdata[49];
            got.ld_p     = o_m_axis_tdata[65:50];
            got.ld_q     = o_m_axis_tdata[81:66];
            if (predicted_status.size() == 0) begin
                $error("status word arrived with no prediction pending");
                n_fail++;
            end else begin
                want = predicted_status.pop_front();
                check_field("oil_temp",         want.oil,      got.oil);
                check_field("tripped",          want.tripped,  got.tripped);
                check_field("apparent_power",   want.apparent, got.apparent);
                check_field("power_factor_out", want.pf,       got.pf);
                check_field("n1_secure",        want.n1,       got.n1);
                check_field("load_active",      want.ld_p,     got.ld_p);
                check_field("load_reactive",    want.ld_q,     got.ld_q);
                n_checked++;
                if (got.tripped === 1'b1) n_trip_seen++;
                if (got.n1 === 1'b1) n_secure_seen++;
            end
        end
    end

    initial begin
        stim_row_t     rows [$];
        relay_status_t none_spec;
        logic [15:0]   regv [7];
        bit            cfg_busy;
        int            k, ph, i, n;

        // Predictor starts from the reset state
        relay_reg[REG_CAP]   = CAP_RST;
        relay_reg[REG_FIRM]  = FIRM_RST;
        relay_reg[REG_UNITS] = UNITS_RST;
        relay_reg[REG_TRIP]  = TRIP_RST;
        relay_reg[REG_RECL]  = RECL_RST;
        relay_reg[REG_RISE]  = RISE_RST;
        relay_reg[REG_GAIN]  = GAIN_RST;
        ld_p_st = 0;
        ld_q_st = 0;
        oil_acc = longint'(OIL_RST);
        amb_st  = AMB_RST;
        trip_st = 1'b0;
        pf_st   = PF_RST;
        cfg_busy = 1'b0;

        // Directed table: tick from reset, presence flags, pf threshold and
        // saturation, trip and reclose, forced trip, N-1, register extremes
        rows.push_back(dir_item(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0));
        rows[0].typed         = 1'b1;
        rows[0].spec.oil      = 16'sd2874;
        rows[0].spec.tripped  = 1'b0;
        rows[0].spec.apparent = 16'd0;
        rows[0].spec.pf       = PF_RST;
        rows[0].spec.n1       = 1'b0;
        rows[0].spec.ld_p     = 16'sd0;
        rows[0].spec.ld_q     = 16'sd0;
        rows.push_back(dir_item(CMD_LOAD,    1, 1, 1, 1, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_LOAD,    1, 2, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_LOAD,    1, -32768, 1, -32768, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_LOAD,    1, 32767, 1, 0, 1, 32767, 0, 0));
        rows.push_back(dir_item(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_LOAD,    0, 0, 0, 0, 1, -32768, 0, 0));
        rows.push_back(dir_item(CMD_WEATHER, 1, 5000, 1, 77, 1, -32768, 1, 1));
        rows.push_back(dir_item(CMD_WEATHER, 0, 0, 0, 0, 1, 32767, 0, 0));
        rows.push_back(dir_item(CMD_WEATHER, 0, 0, 0, 0, 0, 1234, 0, 0));
        rows.push_back(dir_item(CMD_PROT,    0, 0, 0, 0, 1, 9999, 1, 1));
        rows.push_back(dir_item(CMD_LOAD,    0, 0, 0, 0, 1, 6400, 0, 0));
        rows.push_back(dir_item(CMD_PROT,    0, 0, 0, 0, 0, 0, 1, 1));
        rows.push_back(dir_item(CMD_PROT,    0, 0, 0, 0, 0, 0, 1, 0));
        rows.push_back(dir_item(CMD_PROT,    0, 0, 0, 0, 0, 0, 0, 1));
        rows.push_back(dir_item(CMD_TICK,    1, 999, 1, 999, 1, 999, 1, 1));
        rows.push_back(dir_item(CMD_WEATHER, 0, 0, 0, 0, 1, 1600, 0, 0));
        rows.push_back(dir_cfg(REG_UNITS, 16'd2));
        rows.push_back(dir_cfg(REG_FIRM,  16'd640));
        rows.push_back(dir_item(CMD_LOAD,    1, 320, 1, 240, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_LOAD,    1, 640, 1, 1, 0, 0, 0, 0));
        rows.push_back(dir_cfg(REG_CAP,   16'd0));
        rows.push_back(dir_cfg(REG_RISE,  16'd32767));
        rows.push_back(dir_cfg(REG_GAIN,  16'd65535));
        rows.push_back(dir_item(CMD_LOAD,    1, 32767, 1, 32767, 0, 0, 0, 0));
        rows.push_back(dir_item(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_cfg(REG_SPARE, 16'd1234));
        rows.push_back(dir_cfg(REG_GAIN,  16'd0));
        rows.push_back(dir_item(CMD_LOAD,    1, 0, 1, 0, 1, 100, 0, 0));
        rows.push_back(dir_item(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0));
        rows.push_back(dir_cfg(REG_TRIP,  16'hFFFF));
        rows.push_back(dir_cfg(REG_RECL,  16'hFFFF));
        rows.push_back(dir_cfg(REG_UNITS, 16'hFFFF));
        rows.push_back(dir_cfg(REG_FIRM,  16'hFFFF));
        rows.push_back(dir_cfg(REG_CAP,   16'hFFFF));
        rows.push_back(dir_item(CMD_LOAD,    1, -1, 1, -32768, 1, -100, 0, 0));
        rows.push_back(dir_item(CMD_TICK,    0, 0, 0, 0, 0, 0, 0, 0));

        // Hold reset, then release it
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the table; register writes only once the block has drained
        for (k = 0; k < rows.size(); k++) begin
            if (rows[k].is_cfg) begin
                if (!cfg_busy) settle_block();
                write_reg(rows[k].idx, rows[k].val);
                cfg_busy = 1'b1;
            end else begin
                if (cfg_busy) i_cfg_we <= 1'b0;
                cfg_busy = 1'b0;
                offer(rows[k].w, rows[k].typed, rows[k].spec);
            end
        end
        n_settings = 4;

        // Random phases: reset values, realistic, all zero, all ones, anything
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: regv = '{CAP_RST, FIRM_RST, 16'(UNITS_RST), 16'(TRIP_RST),
                            16'(RECL_RST), 16'(RISE_RST), GAIN_RST};
                1: begin
                    regv[REG_CAP]   = 16'($urandom_range(200, 2000));
                    regv[REG_FIRM]  = 16'($urandom_range(0, 2000));
                    regv[REG_UNITS] = 16'($urandom_range(0, 15));
                    regv[REG_TRIP]  = 16'($urandom_range(5000, 9000));
                    regv[REG_RECL]  = regv[REG_TRIP] - 16'($urandom_range(0, 2000));
                    regv[REG_RISE]  = 16'($urandom_range(1000, 8000));
                    regv[REG_GAIN]  = 16'($urandom_range(200, 6000));
                end
                2: regv = '{default: 16'h0000};
                3: regv = '{default: 16'hFFFF};
                default: for (i = 0; i < 7; i++) regv[i] = 16'($urandom);
            endcase
            settle_block();
            for (i = 0; i < 7; i++) write_reg(CFG_IDX_W'(i), regv[i]);
            i_cfg_we <= 1'b0;
            n_settings++;

            for (n = 0; n < 176; n++) begin
                // Let everything drain once mid-run
                if (n_sent == 700) settle_block();
                offer(random_word(), 1'b0, none_spec);
            end
        end

        // Drain and watch for stray words
        settle_block();
        repeat (130) @(posedge i_clk);
        $display("Sent %0d words under %0d register settings, checked %0d status words.",
                 n_sent, n_settings, n_checked);
        $display("Tripped in %0d of them, N-1 secure in %0d.", n_trip_seen, n_secure_seen);
        if (n_fail == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+design
design/thtr_pkg.sv
design/thtr_csu.sv
design/thtr_mul.sv
design/transformer_thermal_trip_model_top.sv
design/thtr_chk.sv
tb/sv/transformer_thermal_trip_model_top_tb.sv
